@@ design/lge_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants of the life grid engine.
// ----------------------------------------------------------------------------
package lge_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_STEP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [6:0] cell_row;
    logic [6:0] cell_column;
    logic       cell_value;
  } in_req_t;

  typedef struct packed {
    logic cell_state;
    logic status;
  } out_rsp_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int POS_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RST    = 7'd64;
  localparam logic [CFG_DATA_W-1:0] COLUMN_COUNT_RST = 7'd64;

  localparam int NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

endpackage

@@ design/lge_cell_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_cell_mem
// Grid storage: one row per entry, one write and one registered read port.
// ----------------------------------------------------------------------------
module lge_cell_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/lge_row_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_row_update
// Next generation of one row from a three-row window, rule B3/S23.
// ----------------------------------------------------------------------------
module lge_row_update #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0] prev_row,
  input  logic [COLS-1:0] cur_row,
  input  logic [COLS-1:0] next_row,
  input  logic [COLS-1:0] col_mask,
  output logic [COLS-1:0] new_row
);
  import lge_pkg::*;

  logic [COLS+1:0]  pad_prev;
  logic [COLS+1:0]  pad_cur;
  logic [COLS+1:0]  pad_next;
  logic [NBR_W-1:0] nbr [COLS];

  assign pad_prev = {1'b0, prev_row & col_mask, 1'b0};
  assign pad_cur  = {1'b0, cur_row  & col_mask, 1'b0};
  assign pad_next = {1'b0, next_row & col_mask, 1'b0};

  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      nbr[j] = NBR_W'(pad_prev[j]) + NBR_W'(pad_prev[j+1]) + NBR_W'(pad_prev[j+2])
             + NBR_W'(pad_cur[j])                        + NBR_W'(pad_cur[j+2])
             + NBR_W'(pad_next[j]) + NBR_W'(pad_next[j+1]) + NBR_W'(pad_next[j+2]);
      if (!col_mask[j]) begin
        new_row[j] = cur_row[j];
      end else if (nbr[j] == BIRTH_COUNT) begin
        new_row[j] = 1'b1;
      end else if (nbr[j] == SURVIVE_COUNT) begin
        new_row[j] = cur_row[j];
      end else begin
        new_row[j] = 1'b0;
      end
    end
  end

endmodule

@@ design/life_grid_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_engine_unit
// Game of Life grid engine: clear, write cell, step generation, read cell.
// ----------------------------------------------------------------------------
// Write or read cell reads the row through the registered read port; step
// sweeps the active rows (one row per cycle through the single read port);
// clear zeroes all MAX_ROWS rows (one row written per cycle). Result is
// registered; one item is in work at a time and the next request can be taken
// in the cycle after the result is registered. Reset: a clearing pass zeroes
// the grid; no item is accepted during it. Row and column counts reset to 64.
module life_grid_engine_unit #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lge_pkg::in_req_t                     in_req,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lge_pkg::out_rsp_t                    out_rsp,
  input  logic                                 cfg_we,
  input  logic [lge_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lge_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import lge_pkg::*;

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_ROWS + 2);
  localparam int NW  = (CW > POS_W) ? CW : POS_W;
  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int NWC = (CCW > POS_W) ? CCW : POS_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CELL = 5'b00010,
    ST_STEP = 5'b00100,
    ST_CLR  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [MAX_COLUMNS-1:0]  win_prev_r, win_prev_nxt;
  logic [MAX_COLUMNS-1:0]  win_cur_r, win_cur_nxt;
  logic                    clr_op_r, clr_op_nxt;
  op_t                     op_r, op_nxt;
  logic                    pos_ok_r, pos_ok_nxt;
  logic [AW-1:0]           row_addr_r, row_addr_nxt;
  logic [CIW-1:0]          col_idx_r, col_idx_nxt;
  logic                    value_r, value_nxt;
  out_rsp_t                pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_rsp_t                out_rsp_r, out_rsp_nxt;
  logic [CFG_DATA_W-1:0]   row_count_r, column_count_r;

  logic [NW-1:0]           nr_w;
  logic [CW-1:0]           nr;
  logic [CW-1:0]           nr_p1;
  logic [NWC-1:0]          nc_w;
  logic [CCW-1:0]          nc;
  logic [MAX_COLUMNS-1:0]  col_mask;
  logic                    in_acc;
  logic                    in_pos_ok;
  logic [NW-1:0]           in_row_m1;
  logic [NWC-1:0]          in_col_m1;
  logic                    out_free;
  logic                    fin;
  out_rsp_t                fin_rsp;
  logic                    mem_rd_en;
  logic [AW-1:0]           mem_rd_addr;
  logic [MAX_COLUMNS-1:0]  mem_rd_data;
  logic                    mem_wr_en;
  logic [AW-1:0]           mem_wr_addr;
  logic [MAX_COLUMNS-1:0]  mem_wr_data;
  logic [MAX_COLUMNS-1:0]  cell_wr_row;
  logic [MAX_COLUMNS-1:0]  next_row;
  logic [MAX_COLUMNS-1:0]  new_row;

  // active size
  assign nr_w  = (NW'(row_count_r) < NW'(MAX_ROWS)) ? NW'(row_count_r) : NW'(MAX_ROWS);
  assign nr    = CW'(nr_w);
  assign nr_p1 = nr + CW'(1);
  assign nc_w  = (NWC'(column_count_r) < NWC'(MAX_COLUMNS)) ?
                 NWC'(column_count_r) : NWC'(MAX_COLUMNS);
  assign nc    = CCW'(nc_w);

  always_comb begin
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      col_mask[j] = (CCW'(j) < nc);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_pos_ok = (in_req.cell_row != '0) && (in_req.cell_column != '0)
                  && (NW'(in_req.cell_row) <= nr_w)
                  && (NWC'(in_req.cell_column) <= nc_w);
  assign in_row_m1 = NW'(in_req.cell_row) - NW'(1);
  assign in_col_m1 = NWC'(in_req.cell_column) - NWC'(1);

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign next_row  = (cnt_r == nr_p1) ? '0 : mem_rd_data;

  lge_cell_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLUMNS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  lge_row_update #(
    .COLS (MAX_COLUMNS)
  ) u_row_update (
    .prev_row (win_prev_r),
    .cur_row  (win_cur_r),
    .next_row (next_row),
    .col_mask (col_mask),
    .new_row  (new_row)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    win_prev_nxt = win_prev_r;
    win_cur_nxt  = win_cur_r;
    clr_op_nxt   = clr_op_r;
    op_nxt       = op_r;
    pos_ok_nxt   = pos_ok_r;
    row_addr_nxt = row_addr_r;
    col_idx_nxt  = col_idx_r;
    value_nxt    = value_r;
    pend_nxt     = pend_r;
    fin          = 1'b0;
    fin_rsp      = '0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = AW'(in_row_m1);
    mem_wr_en    = 1'b0;
    mem_wr_addr  = row_addr_r;
    cell_wr_row  = mem_rd_data;
    cell_wr_row[col_idx_r] = value_r;
    mem_wr_data  = cell_wr_row;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_req.operation;
          pos_ok_nxt   = in_pos_ok;
          row_addr_nxt = AW'(in_row_m1);
          col_idx_nxt  = CIW'(in_col_m1);
          value_nxt    = in_req.cell_value;
          cnt_nxt      = '0;
          unique case (in_req.operation)
            OP_CLEAR: begin
              state_nxt  = ST_CLR;
              clr_op_nxt = 1'b1;
            end
            OP_STEP: begin
              state_nxt   = ST_STEP;
              win_cur_nxt = '0;
            end
            OP_WRITE, OP_READ: begin
              state_nxt = ST_CELL;
              mem_rd_en = in_pos_ok;
            end
          endcase
        end
      end
      ST_CELL: begin
        mem_wr_en          = (op_r == OP_WRITE) && pos_ok_r;
        fin                = 1'b1;
        fin_rsp.cell_state = (op_r == OP_READ) && pos_ok_r && mem_rd_data[col_idx_r];
        fin_rsp.status     = !pos_ok_r;
      end
      ST_STEP: begin
        // read row cnt, retire row cnt-2
        mem_rd_en   = (cnt_r < nr);
        mem_rd_addr = AW'(cnt_r);
        if (cnt_r != '0) begin
          win_prev_nxt = win_cur_r;
          win_cur_nxt  = mem_rd_data;
        end
        if (cnt_r >= CW'(2)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(cnt_r - CW'(2));
          mem_wr_data = new_row;
        end
        if (cnt_r == nr_p1) begin
          fin = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_CLR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(cnt_r);
        mem_wr_data = '0;
        if (cnt_r == CW'(MAX_ROWS - 1)) begin
          if (clr_op_r) begin
            fin = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase

    if (fin) begin
      if (out_free) begin
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_FIN;
        pend_nxt  = fin_rsp;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
      if (state_r == ST_FIN) begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = pend_r;
      end else if (fin) begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = fin_rsp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLR;
      cnt_r          <= '0;
      clr_op_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      row_count_r    <= ROW_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_op_r    <= clr_op_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_COUNT:    row_count_r    <= cfg_wdata;
          REG_COLUMN_COUNT: column_count_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    win_prev_r <= win_prev_nxt;
    win_cur_r  <= win_cur_nxt;
    op_r       <= op_nxt;
    pos_ok_r   <= pos_ok_nxt;
    row_addr_r <= row_addr_nxt;
    col_idx_r  <= col_idx_nxt;
    value_r    <= value_nxt;
    pend_r     <= pend_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mem_wr_en)
    else $error("grid written while idle");

  a_step_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> cnt_r <= nr_p1)
    else $error("step sweep past last row");

  a_step_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && mem_wr_en && mem_rd_en) |-> mem_wr_addr != mem_rd_addr)
    else $error("step read and write hit the same row");

  a_fin_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> out_valid_r)
    else $error("pending result without occupied output");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) != ST_IDLE)
    else $error("result raised from idle");
`endif

endmodule

@@ tb/life_grid_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_engine_unit_tb
// Self-checking bench for the Game of Life grid engine. Requests come from a
// queue and go through a valid/stall driver. Each accepted request is applied
// to a shadow grid that yields the expected response. A monitor compares every
// response with the oldest expected one. Phases change the grid size through
// the config port, and each phase takes one of four idle and stall mixes.
// ----------------------------------------------------------------------------
module life_grid_engine_unit_tb;
  import lge_pkg::*;

  localparam int GRID_DIM     = 64;
  localparam int NUM_PHASES   = 13;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = GRID_DIM + 16;
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  localparam int PHASE_ROWS [NUM_PHASES] =
    '{64, 6, 8, 1, 64, 5, 64, 0, 127, 12, 127, 2, 3};
  localparam int PHASE_COLS [NUM_PHASES] =
    '{64, 8, 8, 1, 64, 64, 64, 64, 3, 0, 127, 2, 4};
  localparam int PHASE_ITEMS [NUM_PHASES] =
    '{23, 150, 150, 60, 250, 100, 100, 40, 130, 30, 130, 60, 80};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_req_t               in_req    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_rsp;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit       shadow_grid [GRID_DIM][GRID_DIM];
  int       shadow_rows = ROW_COUNT_RST;
  int       shadow_cols = COLUMN_COUNT_RST;
  in_req_t  queued_requests [$];
  out_rsp_t awaited_rsps [$];
  out_rsp_t head_rsp;
  int       idle_pct       = 0;
  int       stall_pct      = 0;
  int       queued_count   = 0;
  int       phase_limit    = 0;
  int       mismatch_count = 0;
  bit       req_taken      = 1'b0;
  bit       hold_active    = 1'b0;
  event     hold_trigger;

  life_grid_engine_unit #(
    .MAX_ROWS    (GRID_DIM),
    .MAX_COLUMNS (GRID_DIM)
  ) uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one request to the shadow grid and returns the response it owes.
  function automatic out_rsp_t grid_op_response(in_req_t req);
    out_rsp_t rsp;
    bit       next_grid [GRID_DIM][GRID_DIM];
    int       act_r;
    int       act_c;
    int       live;
    bit       in_range;
    rsp      = '0;
    act_r    = (shadow_rows < GRID_DIM) ? shadow_rows : GRID_DIM;
    act_c    = (shadow_cols < GRID_DIM) ? shadow_cols : GRID_DIM;
    in_range = req.cell_row >= 1 && req.cell_column >= 1 &&
               req.cell_row <= act_r && req.cell_column <= act_c;
    case (req.operation)
      OP_CLEAR: begin
        foreach (shadow_grid[r, c]) shadow_grid[r][c] = 1'b0;
      end
      OP_WRITE: begin
        if (in_range) shadow_grid[req.cell_row - 1][req.cell_column - 1] = req.cell_value;
        else rsp.status = 1'b1;
      end
      OP_STEP: begin
        // cells outside the active area keep their value and count as dead
        next_grid = shadow_grid;
        for (int r = 0; r < act_r; r++) begin
          for (int c = 0; c < act_c; c++) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < act_r &&
                    c + dc >= 0 && c + dc < act_c)
                  live += shadow_grid[r + dr][c + dc];
              end
            end
            if (live == BIRTH_COUNT) next_grid[r][c] = 1'b1;
            else if (live != SURVIVE_COUNT) next_grid[r][c] = 1'b0;
          end
        end
        shadow_grid = next_grid;
      end
      OP_READ: begin
        if (in_range) rsp.cell_state = shadow_grid[req.cell_row - 1][req.cell_column - 1];
        else rsp.status = 1'b1;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void add_req(op_t op, int row, int col, bit val);
    in_req_t req;
    if (queued_count >= phase_limit) return;
    req.operation   = op;
    req.cell_row    = row[POS_W-1:0];
    req.cell_column = col[POS_W-1:0];
    req.cell_value  = val;
    queued_requests.push_back(req);
    queued_count++;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (queued_requests.size() != 0 || in_valid || awaited_rsps.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_req   <= queued_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    out_stall <= hold_active || ($urandom_range(99) < stall_pct);

  initial begin
    @(hold_trigger);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    req_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT:    shadow_rows = cfg_wdata;
          REG_COLUMN_COUNT: shadow_cols = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_rsps.size() == 0) begin
          $error("unexpected response: cell_state %0b status %0b",
                 out_rsp.cell_state, out_rsp.status);
          mismatch_count++;
        end else begin
          head_rsp = awaited_rsps.pop_front();
          if (out_rsp.cell_state !== head_rsp.cell_state) begin
            $error("cell_state mismatch: expected %0b, actual %0b",
                   head_rsp.cell_state, out_rsp.cell_state);
            mismatch_count++;
          end
          if (out_rsp.status !== head_rsp.status) begin
            $error("status mismatch: expected %0b, actual %0b",
                   head_rsp.status, out_rsp.status);
            mismatch_count++;
          end
        end
      end
      if (req_taken) awaited_rsps.push_back(grid_op_response(in_req));
    end
  end

  initial begin
    int act_r;
    int act_c;
    int win_r;
    int win_c;
    int base_r;
    int base_c;
    int pick;
    int win_hist [$];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    win_hist.push_back(0);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // phase 0 runs on the reset sizes
      if (ph != 0) begin
        wait_drained();
        write_reg(REG_ROW_COUNT, PHASE_ROWS[ph]);
        write_reg(REG_COLUMN_COUNT, PHASE_COLS[ph]);
      end
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 48; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      @(posedge clk);
      act_r = (PHASE_ROWS[ph] < GRID_DIM) ? PHASE_ROWS[ph] : GRID_DIM;
      act_c = (PHASE_COLS[ph] < GRID_DIM) ? PHASE_COLS[ph] : GRID_DIM;
      queued_count = 0;
      phase_limit  = PHASE_ITEMS[ph];
      if (ph == 0) begin
        add_req(OP_READ,    1,   1, 1'b1);
        add_req(OP_WRITE,   1,   1, 1'b1);
        add_req(OP_WRITE,   1,   2, 1'b1);
        add_req(OP_WRITE,   2,   1, 1'b1);
        add_req(OP_WRITE,  64,  64, 1'b1);
        add_req(OP_WRITE,   0,   5, 1'b1);
        add_req(OP_WRITE,   5,   0, 1'b1);
        add_req(OP_WRITE,  65,  64, 1'b1);
        add_req(OP_WRITE, 127, 127, 1'b1);
        add_req(OP_READ,   64,  64, 1'b0);
        add_req(OP_READ,    0,   0, 1'b0);
        add_req(OP_READ,   64,  65, 1'b0);
        add_req(OP_READ,  127, 127, 1'b1);
        add_req(OP_STEP,    0,   0, 1'b0);
        add_req(OP_READ,    2,   2, 1'b0);
        add_req(OP_READ,    1,   1, 1'b0);
        add_req(OP_READ,   64,  64, 1'b0);
        add_req(OP_WRITE,   2,   2, 1'b0);
        add_req(OP_READ,    2,   2, 1'b0);
        add_req(OP_CLEAR, 127, 127, 1'b1);
        add_req(OP_READ,    1,   2, 1'b0);
        add_req(OP_STEP,  127, 127, 1'b1);
        add_req(OP_READ,    1,   1, 1'b0);
      end else begin
        // revisit older pattern areas, some now outside the active area
        repeat (8) begin
          pick = win_hist[$urandom_range(win_hist.size() - 1)];
          add_req(OP_READ, pick / 128 + $urandom_range(7), pick % 128 + $urandom_range(7),
                  $urandom_range(1));
        end
        while (queued_count < PHASE_ITEMS[ph]) begin
          if ($urandom_range(9) == 0)
            add_req(OP_CLEAR, $urandom_range(127), $urandom_range(127), $urandom_range(1));
          if (act_r == 0 || act_c == 0) begin
            add_req(OP_STEP, $urandom_range(127), $urandom_range(127), $urandom_range(1));
          end else begin
            win_r = (act_r < 6) ? act_r : 6;
            win_c = (act_c < 6) ? act_c : 6;
            case ($urandom_range(3))
              0:       base_r = 0;
              1:       base_r = act_r - win_r;
              default: base_r = $urandom_range(act_r - win_r);
            endcase
            case ($urandom_range(3))
              0:       base_c = 0;
              1:       base_c = act_c - win_c;
              default: base_c = $urandom_range(act_c - win_c);
            endcase
            win_hist.push_back(base_r * 128 + base_c);
            repeat ($urandom_range(2, win_r * win_c))
              add_req(OP_WRITE, base_r + $urandom_range(1, win_r),
                      base_c + $urandom_range(1, win_c), $urandom_range(3) != 0);
            repeat ($urandom_range(1, 3)) begin
              repeat ($urandom_range(1, 2))
                add_req(OP_STEP, $urandom_range(127), $urandom_range(127),
                        $urandom_range(1));
              // window plus its border, edges may fall out of range
              repeat (12)
                add_req(OP_READ, base_r + $urandom_range(win_r + 1),
                        base_c + $urandom_range(win_c + 1), $urandom_range(1));
            end
          end
          repeat ($urandom_range(3))
            add_req(op_t'($urandom_range(OP_WRITE, OP_READ)), $urandom_range(127),
                    $urandom_range(127), $urandom_range(1));
        end
      end
      if (ph == 4) -> hold_trigger;
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
